@@ rtl/fck_pkg.sv @@
package fck_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W = 5;
  // CORDIC datapath width: d * 256 needs 25+8 bits, growth ~1.65, plus guard
  localparam int CW = 36;
  localparam int ZW = 34;

  localparam logic [31:0] GAIN_COMP = 32'd652032874;

  localparam logic [ZW-1:0] ANG_Q1 = ZW'(34'sd1073741824);

  function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10680862;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670675;
      5'd9: v = 32'd1335343;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return {2'b00, v};
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [CW-1:0] v);
    if (v > CW'(36'sd8388607)) return 24'sh7FFFFF;
    if (v < -CW'(36'sd8388608)) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

@@ rtl/follow_chain_kinematics_unit.sv @@
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid/in_tready   | target_x, target_y
// out_    | out | out_tvalid/out_tready | link_index, pos_x, pos_y, heading, last
// cfg_    | in  | APB, pready tied high | seg_length @0x0, link_count @0x4
//
// Each link runs a setup step, 28 vectoring iterations, a fold step, 28 rotation
// iterations and a writeback, all on one shared CORDIC add/shift unit, then waits for
// the result transfer. An item processes link_count links (clamped to 1..MAX_LINKS) in turn.
// in_tready is high only while the sequencer is idle.
// Reset (rst_n, synchronous) clears the link valid bits, returns to idle and loads seg_length 2560, link_count 32.
// A stalled result holds the sequencer; nothing is dropped.
module follow_chain_kinematics_unit #(
  parameter int MAX_LINKS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // target_x[23:0], target_y[47:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // link_index[4:0], pos_x[28:5], pos_y[52:29],
                                  // heading[68:53], zero fill[71:69]
  output logic        out_tlast,  // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fck_pkg::*;

  localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int NW = $clog2(MAX_LINKS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_VEC = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_ROT = 3'd4;
  localparam logic [2:0] S_WB = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  localparam logic [2:0] ADDR_SEG = 3'd0;
  localparam logic [2:0] ADDR_CNT = 3'd4;

  logic [2:0] state_r;
  logic [15:0] seg_r;
  logic [5:0] cnt_r;
  logic [MAX_LINKS-1:0] vld_r;
  logic signed [23:0] lx_r [MAX_LINKS];
  logic signed [23:0] ly_r [MAX_LINKS];
  logic signed [23:0] px_r, py_r;
  logic [LW-1:0] k_r;
  logic [NW-1:0] n_r;
  logic [STEP_W-1:0] i_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic flip_r, zero_r;
  logic [15:0] h_r;
  logic [71:0] od_r;
  logic ol_r;

  assign cfg_pready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

  always_comb begin
    case (cfg_paddr)
      ADDR_SEG: cfg_prdata = {16'd0, seg_r};
      ADDR_CNT: cfg_prdata = {26'd0, cnt_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // current link position, reset value when never written
  logic signed [23:0] cur_x, cur_y;
  assign cur_x = vld_r[k_r] ? lx_r[k_r] : 24'sd0;
  assign cur_y = vld_r[k_r] ? ly_r[k_r] : 24'sd0;

  // shared CORDIC step
  logic signed [CW-1:0] xs, ys;
  logic dir;
  logic signed [CW-1:0] dx, dy;
  logic signed [47:0] seg_prod;
  logic signed [CW-1:0] rx, ry, ox, oy;
  logic [15:0] hnew;
  logic [NW-1:0] nclamp;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign dir = (state_r == S_VEC) ? (y_r > 0) : (z_r >= 0);
  assign dx = CW'(px_r) - CW'(cur_x);
  assign dy = CW'(py_r) - CW'(cur_y);
  assign hnew = 16'((z_r + ZW'(34'sd32768)) >>> 16);
  assign seg_prod = 48'(({16'd0, seg_r} * {16'd0, GAIN_COMP[31:0]}) >> 22);
  assign rx = (x_r + CW'(128)) >>> 8;
  assign ry = (y_r + CW'(128)) >>> 8;
  assign ox = flip_r ? -rx : rx;
  assign oy = flip_r ? -ry : ry;

  always_comb begin
    if (cnt_r == 6'd0) nclamp = NW'(1);
    else if ({26'd0, cnt_r} > 32'(MAX_LINKS)) nclamp = NW'(MAX_LINKS);
    else nclamp = NW'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seg_r <= 16'd2560;
      cnt_r <= 6'd32;
      vld_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr == ADDR_SEG) seg_r <= cfg_pwdata[15:0];
        else if (cfg_paddr == ADDR_CNT) cnt_r <= cfg_pwdata[5:0];
      end
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          px_r <= in_tdata[23:0];
          py_r <= in_tdata[47:24];
          n_r <= nclamp;
          k_r <= '0;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          i_r <= '0;
          zero_r <= (dx == 0) && (dy == 0);
          if (dx < 0) begin
            if (dy >= 0) begin
              x_r <= dy <<< 8; y_r <= -(dx <<< 8); z_r <= ANG_Q1;
            end else begin
              x_r <= -(dy <<< 8); y_r <= dx <<< 8; z_r <= -ANG_Q1;
            end
          end else begin
            x_r <= dx <<< 8; y_r <= dy <<< 8; z_r <= '0;
          end
          state_r <= S_VEC;
        end
        S_VEC, S_ROT: begin
          if (dir) begin
            x_r <= (state_r == S_VEC) ? x_r + ys : x_r - ys;
            y_r <= (state_r == S_VEC) ? y_r - xs : y_r + xs;
            z_r <= (state_r == S_VEC) ? z_r + atan_turn(i_r) : z_r - atan_turn(i_r);
          end else begin
            x_r <= (state_r == S_VEC) ? x_r - ys : x_r + ys;
            y_r <= (state_r == S_VEC) ? y_r + xs : y_r - xs;
            z_r <= (state_r == S_VEC) ? z_r - atan_turn(i_r) : z_r + atan_turn(i_r);
          end
          if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
            i_r <= '0;
            state_r <= (state_r == S_VEC) ? S_FOLD : S_WB;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_FOLD: begin
          logic [15:0] h;
          h = zero_r ? 16'd0 : hnew;
          h_r <= h;
          // fold into +-90 deg: flip when bits 15:14 are 01 or 10
          flip_r <= h[15] ^ h[14];
          z_r <= (h[15] ^ h[14]) ? ZW'($signed({h - 16'h8000, 16'd0}))
                                 : ZW'($signed({h, 16'd0}));
          x_r <= CW'(seg_prod);
          y_r <= '0;
          state_r <= S_ROT;
        end
        S_WB: begin
          logic signed [23:0] nx, ny;
          nx = sat24(CW'(px_r) - ox);
          ny = sat24(CW'(py_r) - oy);
          lx_r[k_r] <= nx;
          ly_r[k_r] <= ny;
          vld_r[k_r] <= 1'b1;
          px_r <= nx;
          py_r <= ny;
          od_r <= {3'd0, h_r, ny, nx, 5'(k_r)};
          ol_r <= (NW'(k_r) + NW'(1) == n_r);
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          if (ol_r) state_r <= S_IDLE;
          else begin
            k_r <= k_r + 1'b1;
            state_r <= S_SETUP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("no return to idle after last");

endmodule
